// ===== hw/rtl/dhc_pkg.sv =====
package dhc_pkg;

  localparam int POS_W = 17;
  localparam int CNT_W = POS_W + 1;
  localparam int ADDR_W = 5;
  localparam int OUTQ_DEPTH = 4;

  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [POS_W-1:0] POS_MAGIC = 17'd0;
  localparam logic [POS_W-1:0] POS_VT = 17'd2;
  localparam logic [POS_W-1:0] POS_FLAGS = 17'd3;
  localparam logic [POS_W-1:0] POS_CLASS = 17'd4;
  localparam logic [POS_W-1:0] POS_SEQ = 17'd5;
  localparam logic [POS_W-1:0] POS_ACK = 17'd9;
  localparam logic [POS_W-1:0] POS_WIN = 17'd13;
  localparam logic [POS_W-1:0] POS_LEN = 17'd15;
  localparam logic [POS_W-1:0] CRC_FIELD_START = 17'd17;
  localparam logic [POS_W-1:0] HEADER_BYTES = 17'd21;

  localparam logic [31:0] CRC_POLY = 32'h82F63B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_MAGIC = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_LENGTH = 3'd4;
  localparam logic [2:0] ST_CRC = 3'd5;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd6;

  localparam logic [2:0] REG_MAGIC_FIRST = 3'd0;
  localparam logic [2:0] REG_MAGIC_SECOND = 3'd1;
  localparam logic [2:0] REG_PROTOCOL_VERSION = 3'd2;
  localparam logic [2:0] REG_MAX_DATAGRAM = 3'd3;
  localparam logic [2:0] REG_HIGHEST_CLASS = 3'd4;

  localparam logic [16:0] MAX_DATAGRAM_RESET = 17'd1472;
  localparam logic [7:0] HIGHEST_CLASS_RESET = 8'd2;

  typedef struct packed {
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
    logic [3:0]  protocol_version;
    logic [16:0] max_datagram;
    logic [7:0]  highest_class;
  } cfg_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [3:0]  packet_type;
    logic [7:0]  traffic_class;
    logic [31:0] sequence_res;
    logic [31:0] cumulative_ack;
    logic [15:0] advertised_window;
    logic [15:0] payload_length;
    logic        end_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/dhc_regs.sv =====
module dhc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dhc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output dhc_pkg::cfg_t              cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign index = paddr[dhc_pkg::ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_first <= '0;
      cfg.magic_second <= '0;
      cfg.protocol_version <= '0;
      cfg.max_datagram <= dhc_pkg::MAX_DATAGRAM_RESET;
      cfg.highest_class <= dhc_pkg::HIGHEST_CLASS_RESET;
    end else if (wr_en) begin
      unique case (index)
        dhc_pkg::REG_MAGIC_FIRST: cfg.magic_first <= pwdata[7:0];
        dhc_pkg::REG_MAGIC_SECOND: cfg.magic_second <= pwdata[7:0];
        dhc_pkg::REG_PROTOCOL_VERSION: cfg.protocol_version <= pwdata[3:0];
        dhc_pkg::REG_MAX_DATAGRAM: cfg.max_datagram <= pwdata[16:0];
        dhc_pkg::REG_HIGHEST_CLASS: cfg.highest_class <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      dhc_pkg::REG_MAGIC_FIRST: prdata = {24'h0, cfg.magic_first};
      dhc_pkg::REG_MAGIC_SECOND: prdata = {24'h0, cfg.magic_second};
      dhc_pkg::REG_PROTOCOL_VERSION: prdata = {28'h0, cfg.protocol_version};
      dhc_pkg::REG_MAX_DATAGRAM: prdata = {15'h0, cfg.max_datagram};
      dhc_pkg::REG_HIGHEST_CLASS: prdata = {24'h0, cfg.highest_class};
      default: prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/dhc_parser.sv =====
module dhc_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  dhc_pkg::cfg_t cfg,
  output dhc_pkg::push_t push
);

  logic [dhc_pkg::POS_W-1:0] pos, pos_next;
  logic [31:0] crc, crc_next;
  logic [15:0] magic, magic_next;
  logic [7:0]  vt, vt_next;
  logic [7:0]  flags, flags_next;
  logic [7:0]  tclass, tclass_next;
  logic [31:0] seq, seq_next;
  logic [31:0] ack, ack_next;
  logic [15:0] win, win_next;
  logic [15:0] len, len_next;
  logic [31:0] scrc, scrc_next;

  logic [1:0]                lane_seq, lane_ack, lane_scrc;
  logic                      in_crc_field;
  logic                      is_payload;
  logic [dhc_pkg::POS_W-1:0] total;
  logic [dhc_pkg::CNT_W-1:0] count;
  logic [2:0]                stat;
  dhc_pkg::result_t          pay_res, stat_res;

  assign lane_seq = 2'(pos - dhc_pkg::POS_SEQ);
  assign lane_ack = 2'(pos - dhc_pkg::POS_ACK);
  assign lane_scrc = 2'(pos - dhc_pkg::CRC_FIELD_START);
  assign in_crc_field = (pos >= dhc_pkg::CRC_FIELD_START) && (pos < dhc_pkg::HEADER_BYTES);
  assign is_payload = pos >= dhc_pkg::HEADER_BYTES;

  always_comb begin
    magic_next = magic;
    vt_next = vt;
    flags_next = flags;
    tclass_next = tclass;
    seq_next = seq;
    ack_next = ack;
    win_next = win;
    len_next = len;
    scrc_next = scrc;
    if (pos < dhc_pkg::POS_VT) begin
      magic_next[8*pos[0] +: 8] = data_byte;
    end else if (pos == dhc_pkg::POS_VT) begin
      vt_next = data_byte;
    end else if (pos == dhc_pkg::POS_FLAGS) begin
      flags_next = data_byte;
    end else if (pos == dhc_pkg::POS_CLASS) begin
      tclass_next = data_byte;
    end else if (pos < dhc_pkg::POS_ACK) begin
      seq_next[8*lane_seq +: 8] = data_byte;
    end else if (pos < dhc_pkg::POS_WIN) begin
      ack_next[8*lane_ack +: 8] = data_byte;
    end else if (pos < dhc_pkg::POS_LEN) begin
      win_next[8*(pos[0] ^ 1'b1) +: 8] = data_byte;
    end else if (pos < dhc_pkg::CRC_FIELD_START) begin
      len_next[8*(pos[0] ^ 1'b1) +: 8] = data_byte;
    end else if (pos < dhc_pkg::HEADER_BYTES) begin
      scrc_next[8*lane_scrc +: 8] = data_byte;
    end
  end

  assign crc_next = dhc_pkg::crc32c_byte(crc, in_crc_field ? 8'h00 : data_byte);
  assign pos_next = (pos == dhc_pkg::POS_MAX) ? pos : pos + 1'b1;
  assign count = {1'b0, pos} + 1'b1;
  assign total = dhc_pkg::HEADER_BYTES + {1'b0, len_next};

  always_comb begin
    if (count < {1'b0, dhc_pkg::HEADER_BYTES}) begin
      stat = dhc_pkg::ST_SHORT;
    end else if (magic_next != {cfg.magic_second, cfg.magic_first}) begin
      stat = dhc_pkg::ST_MAGIC;
    end else if (vt_next[7:4] != cfg.protocol_version) begin
      stat = dhc_pkg::ST_VERSION;
    end else if ((total > cfg.max_datagram) || (count != {1'b0, total})) begin
      stat = dhc_pkg::ST_LENGTH;
    end else if (~crc_next != scrc_next) begin
      stat = dhc_pkg::ST_CRC;
    end else if ((flags_next != 8'h00) || (tclass_next > cfg.highest_class)) begin
      stat = dhc_pkg::ST_UNSUPPORTED;
    end else begin
      stat = dhc_pkg::ST_OK;
    end
  end

  always_comb begin
    pay_res = '0;
    pay_res.payload_byte = data_byte;
    pay_res.end_of_run = !last_byte;
    stat_res = '0;
    stat_res.out_kind = 1'b1;
    stat_res.status = stat;
    stat_res.packet_type = vt_next[3:0];
    stat_res.traffic_class = tclass_next;
    stat_res.sequence_res = seq_next;
    stat_res.cumulative_ack = ack_next;
    stat_res.advertised_window = win_next;
    stat_res.payload_length = len_next;
    stat_res.end_of_run = 1'b1;
    push.first = is_payload ? pay_res : stat_res;
    push.second = stat_res;
    if (!accept) begin
      push.count = 2'd0;
    end else begin
      push.count = 2'({1'b0, is_payload} + {1'b0, last_byte});
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      pos <= '0;
      crc <= dhc_pkg::CRC_INIT;
      magic <= '0;
      vt <= '0;
      flags <= '0;
      tclass <= '0;
      seq <= '0;
      ack <= '0;
      win <= '0;
      len <= '0;
      scrc <= '0;
    end else if (accept) begin
      pos <= pos_next;
      crc <= crc_next;
      magic <= magic_next;
      vt <= vt_next;
      flags <= flags_next;
      tclass <= tclass_next;
      seq <= seq_next;
      ack <= ack_next;
      win <= win_next;
      len <= len_next;
      scrc <= scrc_next;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> (pos == '0) && (crc == dhc_pkg::CRC_INIT))
    else $error("datagram state not cleared after last beat");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    accept && !last_byte && (pos != dhc_pkg::POS_MAX) |=> pos == $past(pos) + 1'b1)
    else $error("byte position did not advance");

endmodule

// ===== hw/rtl/dhc_outq.sv =====
module dhc_outq #(
  parameter int DEPTH = dhc_pkg::OUTQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  dhc_pkg::push_t   push,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output dhc_pkg::result_t out_res
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QCNT_W = $clog2(DEPTH + 1);

  dhc_pkg::result_t entries [DEPTH];

  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next, wr_ptr1, rd_ptr;
  logic [QCNT_W-1:0] cnt, cnt_next;
  logic              pop;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop = out_valid && out_ready;
  assign out_valid = cnt != '0;
  assign out_res = entries[rd_ptr];
  assign in_ready = cnt <= QCNT_W'(DEPTH - 2);
  assign wr_ptr1 = bump(wr_ptr);
  assign cnt_next = cnt + QCNT_W'(push.count) - QCNT_W'(pop);

  always_comb begin
    case (push.count)
      2'd1: wr_ptr_next = wr_ptr1;
      2'd2: wr_ptr_next = bump(wr_ptr1);
      default: wr_ptr_next = wr_ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      cnt <= cnt_next;
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr1] <= push.second;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (cnt <= QCNT_W'(DEPTH - 2)))
    else $error("result beat pushed while queue lacks room");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    pop && (push.count == 2'd0) |=> cnt == $past(cnt) - 1'b1)
    else $error("queue count wrong after pop");

endmodule

// ===== hw/rtl/datagram_header_checker_crc32c.sv =====
// Result beats are registered in a small result queue before they are offered.
// Throughput: one input byte per cycle while in_ready is high; a final byte at
// offset 21 or later gives two beats, drained one per cycle when out_ready is high.
// Input ready drops only when the result queue lacks room for two beats.
// Reset (rst, synchronous): clears byte position, CRC to all ones, captured header,
// empties the result queue and loads register defaults.
module datagram_header_checker_crc32c #(
  parameter int OUTQ_DEPTH = dhc_pkg::OUTQ_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dhc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 data_byte,
  input  logic                       last_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_kind,
  output logic [7:0]                 payload_byte,
  output logic [2:0]                 status,
  output logic [3:0]                 packet_type,
  output logic [7:0]                 traffic_class,
  output logic [31:0]                sequence_res,
  output logic [31:0]                cumulative_ack,
  output logic [15:0]                advertised_window,
  output logic [15:0]                payload_length,
  output logic                       end_of_run
);

  dhc_pkg::cfg_t    cfg;
  dhc_pkg::push_t   push;
  dhc_pkg::result_t res;
  logic             accept;

  assign pready = 1'b1;
  assign accept = in_valid && in_ready;

  dhc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  dhc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .cfg       (cfg),
    .push      (push)
  );

  dhc_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_kind = res.out_kind;
  assign payload_byte = res.payload_byte;
  assign status = res.status;
  assign packet_type = res.packet_type;
  assign traffic_class = res.traffic_class;
  assign sequence_res = res.sequence_res;
  assign cumulative_ack = res.cumulative_ack;
  assign advertised_window = res.advertised_window;
  assign payload_length = res.payload_length;
  assign end_of_run = res.end_of_run;

endmodule
